FILE: hdl/pse_pkg.sv
// Package for the postfix stack evaluator: operation, status and ALU codes,
// symbol constants, the ALU control/response structs and the symbol decoders.
// No dependencies.
package pse_pkg;

    localparam int NUM_VARS = 52;
    localparam int VIDX_W   = 6;

    typedef logic [1:0] t_opn;
    localparam t_opn OPN_LOAD  = 2'd0;
    localparam t_opn OPN_EVAL  = 2'd1;
    localparam t_opn OPN_CLEAR = 2'd2;

    typedef logic [1:0] t_status;
    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_UNDER = 2'd1;
    localparam t_status ST_OVER  = 2'd2;
    localparam t_status ST_DIVZ  = 2'd3;

    typedef logic [3:0] t_alu_op;
    localparam t_alu_op ALU_ADD  = 4'd0;
    localparam t_alu_op ALU_SUB  = 4'd1;
    localparam t_alu_op ALU_MUL  = 4'd2;
    localparam t_alu_op ALU_DIV  = 4'd3;
    localparam t_alu_op ALU_AND  = 4'd4;
    localparam t_alu_op ALU_OR   = 4'd5;
    localparam t_alu_op ALU_EQ   = 4'd6;
    localparam t_alu_op ALU_NE   = 4'd7;
    localparam t_alu_op ALU_LT   = 4'd8;
    localparam t_alu_op ALU_GT   = 4'd9;
    localparam t_alu_op ALU_ZERO = 4'd10;

    localparam logic [7:0] SYM_DIV   = 8'h2F;
    localparam logic [7:0] SYM_MUL   = 8'h2A;
    localparam logic [7:0] SYM_ADD   = 8'h2B;
    localparam logic [7:0] SYM_SUB   = 8'h2D;
    localparam logic [7:0] SYM_AND   = 8'h26;
    localparam logic [7:0] SYM_OR    = 8'h7C;
    localparam logic [7:0] SYM_EQ    = 8'h3D;
    localparam logic [7:0] SYM_NE    = 8'h7E;
    localparam logic [7:0] SYM_LT    = 8'h3C;
    localparam logic [7:0] SYM_GT    = 8'h3E;
    localparam logic [7:0] SYM_DIG_0 = 8'd48;
    localparam logic [7:0] SYM_DIG_9 = 8'h39;
    localparam logic [7:0] SYM_UC_A  = 8'h41;
    localparam logic [7:0] SYM_UC_Z  = 8'h5A;
    localparam logic [7:0] SYM_LC_A  = 8'h61;
    localparam logic [7:0] SYM_LC_Z  = 8'h7A;
    localparam logic [7:0] LC_BASE   = 8'd26;

    typedef struct packed {
        logic    start;
        t_alu_op op;
    } t_alu_ctl;

    typedef struct packed {
        logic done;
        logic divz;
    } t_alu_rsp;

    function automatic logic is_letter(input logic [7:0] sym);
        return sym inside {[SYM_UC_A:SYM_UC_Z], [SYM_LC_A:SYM_LC_Z]};
    endfunction

    function automatic logic is_digit(input logic [7:0] sym);
        return sym inside {[SYM_DIG_0:SYM_DIG_9]};
    endfunction

    function automatic logic [VIDX_W-1:0] var_index(input logic [7:0] sym);
        logic [7:0] d;
        if (sym inside {[SYM_UC_A:SYM_UC_Z]}) begin
            d = sym - SYM_UC_A;
        end else begin
            d = sym - SYM_LC_A + LC_BASE;
        end
        return d[VIDX_W-1:0];
    endfunction

    function automatic t_alu_op alu_op_of(input logic [7:0] sym);
        t_alu_op op;
        case (sym)
            SYM_DIV: op = ALU_DIV;
            SYM_MUL: op = ALU_MUL;
            SYM_ADD: op = ALU_ADD;
            SYM_SUB: op = ALU_SUB;
            SYM_AND: op = ALU_AND;
            SYM_OR:  op = ALU_OR;
            SYM_EQ:  op = ALU_EQ;
            SYM_NE:  op = ALU_NE;
            SYM_LT:  op = ALU_LT;
            SYM_GT:  op = ALU_GT;
            default: op = ALU_ZERO;
        endcase
        return op;
    endfunction

endpackage

FILE: hdl/postfix_stack_evaluator_top.sv
// Top level of the postfix stack evaluator: request control, operand stack
// memory with a top-of-stack register, result register.
// Depends on pse_pkg, pse_var_table and pse_serial_alu.
//
// Usage: one request on the input channel (i_in_valid / o_in_stall) carries
// i_operation, i_symbol and i_value; each request gives exactly one result on
// the output channel (o_out_valid / i_out_stall) with the top of stack, the
// entry count and a status code.
// Load, clear, digit push and stack errors go from acceptance to the done
// state and then to the result register; a letter push first passes the
// variable table read state; an operator reads its second operand, then
// runs the serial ALU, one bit per cycle for all operators, one quotient
// bit per cycle for division; division by zero skips the ALU run.
// Throughput: one request at a time; o_in_stall is high from acceptance
// until the result is in the result register.
// Reset clears the stack pointer, the variable table valid bits and the
// result valid flag; the variable table then reads zero for every letter.
// While the receiver stalls, the result holds; the next request is accepted
// and evaluated, but its result waits for the result register to free.
module postfix_stack_evaluator_top import pse_pkg::*; #(
    parameter int STACK_DEPTH = 16,
    parameter int WORD_WIDTH  = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_operation,
    input  logic [7:0]         i_symbol,
    input  logic signed [31:0] i_value,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_top_value,
    output logic [4:0]         o_stack_count,
    output logic [1:0]         o_status
);

    localparam int AW  = $clog2(STACK_DEPTH);
    localparam int SPW = $clog2(STACK_DEPTH + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_VAR  = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_ALU  = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0]            r_state, n_state;
    logic [SPW-1:0]        r_sp, n_sp;
    logic [WORD_WIDTH-1:0] r_tos, n_tos;
    t_status               r_status, n_status;
    logic [7:0]            r_sym;
    logic [WORD_WIDTH-1:0] r_stack [STACK_DEPTH];
    logic [WORD_WIDTH-1:0] r_stk_rd;
    logic                  r_out_valid;
    logic [31:0]           r_out_top;
    logic [4:0]            r_out_count;
    t_status               r_out_status;

    logic                  accept;
    logic                  in_letter;
    logic                  in_digit;
    logic                  full;
    logic                  few;
    logic [SPW-1:0]        sp_m2;
    logic [7:0]            dig;
    logic [WORD_WIDTH-1:0] dig_word;
    logic                  vt_we;
    logic                  vt_re;
    logic [WORD_WIDTH-1:0] vt_rd;
    logic                  stk_re;
    logic                  stk_we;
    logic [AW-1:0]         stk_wa;
    logic [WORD_WIDTH-1:0] stk_wd;
    t_alu_ctl              alu_ctl;
    t_alu_rsp              alu_rsp;
    logic [WORD_WIDTH-1:0] alu_res;
    logic                  out_load;
    logic [31:0]           top32;
    logic [4:0]            count5;

    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && !o_in_stall;
    assign in_letter  = is_letter(i_symbol);
    assign in_digit   = is_digit(i_symbol);
    assign full       = (r_sp == SPW'(STACK_DEPTH));
    assign few        = (r_sp < SPW'(2));
    assign sp_m2      = r_sp - SPW'(2);
    assign dig        = i_symbol - SYM_DIG_0;
    assign dig_word   = {{(WORD_WIDTH-4){1'b0}}, dig[3:0]};

    assign vt_we  = accept && (i_operation == OPN_LOAD) && in_letter;
    assign vt_re  = accept && (i_operation == OPN_EVAL) && in_letter && !full;
    assign stk_re = accept && (i_operation == OPN_EVAL) && !in_letter && !in_digit && !few;

    pse_var_table #(
        .WORD_WIDTH(WORD_WIDTH)
    ) u_vars (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (vt_we),
        .i_wr_idx  (var_index(i_symbol)),
        .i_wr_data (WORD_WIDTH'(i_value)),
        .i_rd_en   (vt_re),
        .i_rd_idx  (var_index(i_symbol)),
        .o_rd_data (vt_rd)
    );

    assign alu_ctl.start = (r_state == S_RD);
    assign alu_ctl.op    = alu_op_of(r_sym);

    pse_serial_alu #(
        .WORD_WIDTH(WORD_WIDTH)
    ) u_alu (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (alu_ctl),
        .i_a      (r_stk_rd),
        .i_b      (r_tos),
        .o_rsp    (alu_rsp),
        .o_result (alu_res)
    );

    assign out_load = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);

    always_comb begin
        n_state  = r_state;
        n_sp     = r_sp;
        n_tos    = r_tos;
        n_status = r_status;
        stk_we   = 1'b0;
        stk_wa   = r_sp[AW-1:0];
        stk_wd   = vt_rd;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_status = ST_OK;
                    n_state  = S_DONE;
                    case (i_operation)
                        OPN_EVAL: begin
                            if (in_letter) begin
                                if (full) begin
                                    n_status = ST_OVER;
                                end else begin
                                    n_state = S_VAR;
                                end
                            end else if (in_digit) begin
                                if (full) begin
                                    n_status = ST_OVER;
                                end else begin
                                    stk_we = 1'b1;
                                    stk_wd = dig_word;
                                    n_tos  = dig_word;
                                    n_sp   = r_sp + 1'b1;
                                end
                            end else if (few) begin
                                n_status = ST_UNDER;
                            end else begin
                                n_state = S_RD;
                            end
                        end
                        OPN_CLEAR: n_sp = '0;
                        default: ;
                    endcase
                end
            end
            S_VAR: begin
                stk_we  = 1'b1;
                n_tos   = vt_rd;
                n_sp    = r_sp + 1'b1;
                n_state = S_DONE;
            end
            S_RD: n_state = S_ALU;
            S_ALU: begin
                if (alu_rsp.done) begin
                    stk_we   = 1'b1;
                    stk_wa   = sp_m2[AW-1:0];
                    stk_wd   = alu_res;
                    n_tos    = alu_res;
                    n_sp     = r_sp - 1'b1;
                    n_status = alu_rsp.divz ? ST_DIVZ : ST_OK;
                    n_state  = S_DONE;
                end
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sp        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sp    <= n_sp;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_tos    <= n_tos;
        r_status <= n_status;
        if (accept) begin
            r_sym <= i_symbol;
        end
        if (stk_we) begin
            r_stack[stk_wa] <= stk_wd;
        end
        if (stk_re) begin
            r_stk_rd <= r_stack[sp_m2[AW-1:0]];
        end
        if (out_load) begin
            r_out_top    <= (r_sp != '0) ? top32 : '0;
            r_out_count  <= count5;
            r_out_status <= r_status;
        end
    end

    generate
        if (WORD_WIDTH >= 32) begin : g_top_trunc
            assign top32 = r_tos[31:0];
        end else begin : g_top_ext
            assign top32 = {{(32-WORD_WIDTH){1'b0}}, r_tos};
        end
        if (SPW >= 5) begin : g_cnt_trunc
            assign count5 = r_sp[4:0];
        end else begin : g_cnt_ext
            assign count5 = {{(5-SPW){1'b0}}, r_sp};
        end
    endgenerate

    assign o_out_valid   = r_out_valid;
    assign o_top_value   = r_out_top;
    assign o_stack_count = r_out_count;
    assign o_status      = r_out_status;

endmodule

FILE: hdl/pse_var_table.sv
// Variable table of the postfix stack evaluator: 52 words with per-entry
// valid bits so that unwritten letters read as zero; registered read.
// Depends on pse_pkg.
module pse_var_table import pse_pkg::*; #(
    parameter int WORD_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_wr_en,
    input  logic [VIDX_W-1:0]     i_wr_idx,
    input  logic [WORD_WIDTH-1:0] i_wr_data,
    input  logic                  i_rd_en,
    input  logic [VIDX_W-1:0]     i_rd_idx,
    output logic [WORD_WIDTH-1:0] o_rd_data
);

    logic [WORD_WIDTH-1:0] r_mem [NUM_VARS];
    logic [NUM_VARS-1:0]   r_valid;
    logic [WORD_WIDTH-1:0] r_rd_data;
    logic                  r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr_en) begin
            r_valid[i_wr_idx] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_idx] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data  <= r_mem[i_rd_idx];
            r_rd_valid <= r_valid[i_rd_idx];
        end
    end

    assign o_rd_data = r_rd_valid ? r_rd_data : '0;

endmodule

FILE: hdl/pse_serial_alu.sv
// Serial ALU of the postfix stack evaluator: one bit per cycle for add,
// subtract, and/or and compares, shift-add multiply and restoring
// divide. Depends on pse_pkg.
module pse_serial_alu import pse_pkg::*; #(
    parameter int WORD_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_alu_ctl              i_ctl,
    input  logic [WORD_WIDTH-1:0] i_a,
    input  logic [WORD_WIDTH-1:0] i_b,
    output t_alu_rsp              o_rsp,
    output logic [WORD_WIDTH-1:0] o_result
);

    localparam int CW = $clog2(WORD_WIDTH);
    localparam logic [CW-1:0] LAST = CW'(WORD_WIDTH - 1);

    localparam logic [1:0] A_IDLE = 2'd0;
    localparam logic [1:0] A_RUN  = 2'd1;
    localparam logic [1:0] A_FIX  = 2'd2;

    logic [1:0]            r_state;
    logic [CW-1:0]         r_cnt;
    logic                  r_done;
    logic                  r_divz;
    t_alu_op               r_op;
    logic [WORD_WIDTH-1:0] r_sa;
    logic [WORD_WIDTH-1:0] r_sb;
    logic [WORD_WIDTH-1:0] r_acc;
    logic [WORD_WIDTH-1:0] r_res;
    logic                  r_carry;
    logic                  r_any_a;
    logic                  r_any_b;
    logic                  r_diff;
    logic                  r_lt;
    logic                  r_neg;

    logic                  b_zero;
    logic                  start_inv;
    logic                  run_inv;
    logic                  bb;
    logic                  sbit;
    logic                  cout;
    logic [WORD_WIDTH-1:0] rem_sh;
    logic                  ge;
    logic [WORD_WIDTH-1:0] rem_nx;
    logic [WORD_WIDTH-1:0] mul_sum;
    logic [WORD_WIDTH-1:0] mag_a;
    logic [WORD_WIDTH-1:0] mag_b;
    logic [WORD_WIDTH-1:0] fix_res;

    assign b_zero    = (i_b == '0);
    assign start_inv = i_ctl.op inside {ALU_SUB, ALU_LT, ALU_GT};
    assign run_inv   = r_op inside {ALU_SUB, ALU_LT, ALU_GT};

    assign bb   = r_sb[0] ^ run_inv;
    assign sbit = r_sa[0] ^ bb ^ r_carry;
    assign cout = (r_sa[0] & bb) | (r_sa[0] & r_carry) | (bb & r_carry);

    assign rem_sh  = {r_acc[WORD_WIDTH-2:0], r_sa[WORD_WIDTH-1]};
    assign ge      = (rem_sh >= r_sb);
    assign rem_nx  = ge ? (rem_sh - r_sb) : rem_sh;
    assign mul_sum = r_acc + r_sa;

    assign mag_a = i_a[WORD_WIDTH-1] ? (~i_a + 1'b1) : i_a;
    assign mag_b = i_b[WORD_WIDTH-1] ? (~i_b + 1'b1) : i_b;

    always_comb begin
        case (r_op)
            ALU_ADD, ALU_SUB, ALU_MUL: fix_res = r_acc;
            ALU_DIV: fix_res = r_neg ? (~r_sa + 1'b1) : r_sa;
            ALU_AND: fix_res = {{(WORD_WIDTH-1){1'b0}}, r_any_a & r_any_b};
            ALU_OR:  fix_res = {{(WORD_WIDTH-1){1'b0}}, r_any_a | r_any_b};
            ALU_EQ:  fix_res = {{(WORD_WIDTH-1){1'b0}}, ~r_diff};
            ALU_NE:  fix_res = {{(WORD_WIDTH-1){1'b0}}, r_diff};
            ALU_LT:  fix_res = {{(WORD_WIDTH-1){1'b0}}, r_lt};
            ALU_GT:  fix_res = {{(WORD_WIDTH-1){1'b0}}, ~r_lt & r_diff};
            default: fix_res = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= A_IDLE;
            r_cnt   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                A_IDLE: begin
                    if (i_ctl.start) begin
                        r_cnt <= '0;
                        if (i_ctl.op == ALU_DIV && b_zero) begin
                            r_done <= 1'b1;
                        end else begin
                            r_state <= A_RUN;
                        end
                    end
                end
                A_RUN: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == LAST) begin
                        r_state <= A_FIX;
                    end
                end
                A_FIX: begin
                    r_done  <= 1'b1;
                    r_state <= A_IDLE;
                end
                default: r_state <= A_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            A_IDLE: begin
                if (i_ctl.start) begin
                    r_op    <= i_ctl.op;
                    r_carry <= start_inv;
                    r_any_a <= 1'b0;
                    r_any_b <= 1'b0;
                    r_diff  <= 1'b0;
                    r_acc   <= '0;
                    r_divz  <= 1'b0;
                    if (i_ctl.op == ALU_DIV) begin
                        r_sa  <= mag_a;
                        r_sb  <= mag_b;
                        r_neg <= i_a[WORD_WIDTH-1] ^ i_b[WORD_WIDTH-1];
                        if (b_zero) begin
                            r_divz <= 1'b1;
                            r_res  <= '0;
                        end
                    end else begin
                        r_sa <= i_a;
                        r_sb <= i_b;
                    end
                end
            end
            A_RUN: begin
                case (r_op)
                    ALU_MUL: begin
                        if (r_sb[0]) begin
                            r_acc <= mul_sum;
                        end
                        r_sa <= {r_sa[WORD_WIDTH-2:0], 1'b0};
                        r_sb <= {1'b0, r_sb[WORD_WIDTH-1:1]};
                    end
                    ALU_DIV: begin
                        r_acc <= rem_nx;
                        r_sa  <= {r_sa[WORD_WIDTH-2:0], ge};
                    end
                    default: begin
                        r_acc   <= {sbit, r_acc[WORD_WIDTH-1:1]};
                        r_carry <= cout;
                        r_sa    <= {1'b0, r_sa[WORD_WIDTH-1:1]};
                        r_sb    <= {1'b0, r_sb[WORD_WIDTH-1:1]};
                        r_any_a <= r_any_a | r_sa[0];
                        r_any_b <= r_any_b | r_sb[0];
                        r_diff  <= r_diff | (r_sa[0] ^ r_sb[0]);
                        if (r_cnt == LAST) begin
                            r_lt <= (r_sa[0] != r_sb[0]) ? r_sa[0] : sbit;
                        end
                    end
                endcase
            end
            A_FIX: r_res <= fix_res;
            default: ;
        endcase
    end

    assign o_rsp.done = r_done;
    assign o_rsp.divz = r_divz;
    assign o_result   = r_res;

endmodule

FILE: hdl/pse_checker.sv
// Port-level checker for the postfix stack evaluator, bound to the top level.
// Depends on pse_pkg and postfix_stack_evaluator_top.
module pse_checker import pse_pkg::*; #(
    parameter int STACK_DEPTH = 16
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [31:0] o_top_value,
    input logic [4:0]  o_stack_count,
    input logic [1:0]  o_status
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_top_value)
            && $stable(o_stack_count) && $stable(o_status))
        else $error("stalled result changed");

    a_over_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_OVER) |-> o_stack_count == 5'(STACK_DEPTH))
        else $error("overflow reported on a stack that is not full");

    a_under_few: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_UNDER) |-> o_stack_count < 5'd2)
        else $error("underflow reported with two or more entries");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_stack_count == 5'd0) && (STACK_DEPTH < 32)
            |-> o_top_value == 32'd0)
        else $error("empty stack shows a nonzero top");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

endmodule

bind postfix_stack_evaluator_top pse_checker #(.STACK_DEPTH(STACK_DEPTH)) u_pse_checker (.*);
